// ----- rtl/core/mrtu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtu_pkg
// Shared types, constants and CRC helpers of the Modbus RTU master core.
// ----------------------------------------------------------------------------
package mrtu_pkg;

  // Reply frame geometry
  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned REQ_BODY_BYTES = 6;
  localparam int unsigned FRAME_IDX_W = $clog2(FRAME_BYTES);
  localparam int unsigned REPLY_CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int unsigned ERR_FRAME_BYTES = 4;

  // Request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // CRC-16 (reflected)
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [2:0] REG_SLAVE_ADDRESS = 3'd0;
  localparam logic [2:0] REG_WRITE_CODE = 3'd1;
  localparam logic [2:0] REG_READ_CODE = 3'd2;
  localparam logic [2:0] REG_CRC_ERROR_CODE = 3'd3;
  localparam logic [2:0] REG_REGISTER_ERROR_CODE = 3'd4;
  localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd5;
  localparam logic [2:0] REG_CRC_HIGH_FIRST = 3'd6;

  // Register reset values
  localparam logic [7:0] RST_SLAVE_ADDRESS = 8'd1;
  localparam logic [7:0] RST_WRITE_CODE = 8'd6;
  localparam logic [7:0] RST_READ_CODE = 8'd3;
  localparam logic [7:0] RST_CRC_ERROR_CODE = 8'd1;
  localparam logic [7:0] RST_REGISTER_ERROR_CODE = 8'd2;
  localparam logic [7:0] RST_TIMEOUT_TICKS = 8'd186;
  localparam logic RST_CRC_HIGH_FIRST = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_BYTE  = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_READY     = 3'd0,
    ST_RECEIVING = 3'd1,
    ST_OK        = 3'd2,
    ST_FRAME_ERR = 3'd3,
    ST_TIMEOUT   = 3'd4,
    ST_CRC_ERR   = 3'd5,
    ST_REG_ERR   = 3'd6
  } link_status_t;

  typedef struct packed {
    logic [7:0] slave_address;
    logic [7:0] write_code;
    logic [7:0] read_code;
    logic [7:0] crc_error_code;
    logic [7:0] register_error_code;
    logic [7:0] timeout_ticks;
    logic       crc_high_first;
  } cfg_t;

  // One queued request: a frame to send, or a single status report
  typedef struct packed {
    logic                                 is_frame;
    logic                                 accepted;
    link_status_t                         status;
    logic [15:0]                          read_data;
    logic [REQ_BODY_BYTES-1:0][7:0]       body;
  } entry_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] crc_first(input logic [15:0] c, input logic high_first);
    return high_first ? c[15:8] : c[7:0];
  endfunction

  function automatic logic [7:0] crc_second(input logic [15:0] c, input logic high_first);
    return high_first ? c[7:0] : c[15:8];
  endfunction

endpackage

// ----- rtl/core/mrtu_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtu_queue
// Small FIFO of request entries between the front and back parts.
// ----------------------------------------------------------------------------
module mrtu_queue #(
  parameter int unsigned DEPTH = mrtu_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mrtu_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output mrtu_pkg::entry_t pop_data,
  output logic            empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  mrtu_pkg::entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/mrtu_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtu_front
// Takes requests, tracks the link state and the reply, queues one entry each.
// ----------------------------------------------------------------------------
module mrtu_front (
  input  logic             clk,
  input  logic             rst_n,
  input  mrtu_pkg::cfg_t   cfg,
  input  logic             accept,
  input  logic [1:0]       operation,
  input  logic [15:0]      reg_address,
  input  logic [15:0]      write_value,
  input  logic [7:0]       rx_byte,
  output mrtu_pkg::entry_t entry
);

  localparam int unsigned IDX_W = mrtu_pkg::FRAME_IDX_W;
  localparam int unsigned CNT_W = mrtu_pkg::REPLY_CNT_W;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(mrtu_pkg::FRAME_BYTES - 1);
  localparam logic [CNT_W-1:0] BODY_CNT = CNT_W'(mrtu_pkg::REQ_BODY_BYTES);
  localparam logic [CNT_W-1:0] ERR_CNT = CNT_W'(mrtu_pkg::ERR_FRAME_BYTES);

  mrtu_pkg::link_status_t status_r, status_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       tick_r, tick_nxt, tick_inc;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       buf_r [mrtu_pkg::FRAME_BYTES];
  logic             buf_we;
  logic [15:0]      read_value;
  logic             good, crc_err_hit, reg_err_hit;

  // Error frame CRCs, refreshed every cycle from the registers
  logic [15:0] slave_crc_r, crc_err_crc_r, reg_err_crc_r;

  always_ff @(posedge clk) begin
    slave_crc_r   <= mrtu_pkg::crc_add(mrtu_pkg::CRC_INIT, cfg.slave_address);
    crc_err_crc_r <= mrtu_pkg::crc_add(slave_crc_r, cfg.crc_error_code);
    reg_err_crc_r <= mrtu_pkg::crc_add(slave_crc_r, cfg.register_error_code);
  end

  assign read_value = write_value;
  assign tick_inc   = (tick_r == 8'hFF) ? 8'hFF : tick_r + 8'd1;
  assign good = (buf_r[6] == mrtu_pkg::crc_first(crc_r, cfg.crc_high_first)) &&
                (rx_byte == mrtu_pkg::crc_second(crc_r, cfg.crc_high_first));
  assign crc_err_hit =
    (buf_r[2] == mrtu_pkg::crc_first(crc_err_crc_r, cfg.crc_high_first)) &&
    (buf_r[3] == mrtu_pkg::crc_second(crc_err_crc_r, cfg.crc_high_first));
  assign reg_err_hit =
    (buf_r[2] == mrtu_pkg::crc_first(reg_err_crc_r, cfg.crc_high_first)) &&
    (buf_r[3] == mrtu_pkg::crc_second(reg_err_crc_r, cfg.crc_high_first));

  always_comb begin
    status_nxt = status_r;
    count_nxt  = count_r;
    tick_nxt   = tick_r;
    crc_nxt    = crc_r;
    buf_we     = 1'b0;
    entry      = '0;
    unique case (mrtu_pkg::op_t'(operation))
      mrtu_pkg::OP_WRITE, mrtu_pkg::OP_READ: begin
        if (status_r != mrtu_pkg::ST_RECEIVING) begin
          status_nxt = mrtu_pkg::ST_RECEIVING;
          count_nxt  = '0;
          tick_nxt   = '0;
          crc_nxt    = mrtu_pkg::CRC_INIT;
          entry.is_frame = 1'b1;
          entry.accepted = 1'b1;
          entry.body[0]  = cfg.slave_address;
          entry.body[2]  = reg_address[15:8];
          entry.body[3]  = reg_address[7:0];
          if (mrtu_pkg::op_t'(operation) == mrtu_pkg::OP_WRITE) begin
            entry.body[1] = cfg.write_code;
            entry.body[4] = read_value[15:8];
            entry.body[5] = read_value[7:0];
          end else begin
            entry.body[1] = cfg.read_code;
            entry.body[4] = 8'h00;
            entry.body[5] = 8'h01;
          end
        end
      end
      mrtu_pkg::OP_BYTE: begin
        if (status_r == mrtu_pkg::ST_RECEIVING) begin
          buf_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          if (count_r < BODY_CNT) begin
            crc_nxt = mrtu_pkg::crc_add(crc_r, rx_byte);
          end
          if (count_r == LAST_CNT) begin
            status_nxt = good ? mrtu_pkg::ST_OK : mrtu_pkg::ST_FRAME_ERR;
            tick_nxt   = '0;
          end
        end
      end
      mrtu_pkg::OP_TICK: begin
        if (status_r == mrtu_pkg::ST_RECEIVING) begin
          tick_nxt = tick_inc;
          if (tick_inc >= cfg.timeout_ticks) begin
            tick_nxt = '0;
            if (count_r == ERR_CNT && crc_err_hit) begin
              status_nxt = mrtu_pkg::ST_CRC_ERR;
            end else if (count_r == ERR_CNT && reg_err_hit) begin
              status_nxt = mrtu_pkg::ST_REG_ERR;
            end else begin
              status_nxt = mrtu_pkg::ST_TIMEOUT;
            end
          end
        end
      end
    endcase
    entry.status = status_nxt;
    // Bytes 4 and 5 are in place before the eighth byte settles the frame
    if (status_nxt == mrtu_pkg::ST_OK || status_nxt == mrtu_pkg::ST_FRAME_ERR) begin
      entry.read_data = {buf_r[4], buf_r[5]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= mrtu_pkg::ST_READY;
      count_r  <= '0;
      tick_r   <= '0;
      crc_r    <= mrtu_pkg::CRC_INIT;
    end else if (accept) begin
      status_r <= status_nxt;
      count_r  <= count_nxt;
      tick_r   <= tick_nxt;
      crc_r    <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && buf_we) begin
      buf_r[count_r[IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule

// ----- rtl/core/mrtu_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtu_back
// Drains queued entries: sends a request frame byte by byte with its CRC, or
// reports a single status result.
// ----------------------------------------------------------------------------
module mrtu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             crc_high_first,
  input  logic             q_empty,
  input  mrtu_pkg::entry_t q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_tx_byte,
  output logic             out_tx_valid,
  output logic             out_last,
  output logic             out_accepted,
  output logic [2:0]       out_status,
  output logic [15:0]      out_read_data
);

  localparam int unsigned IDX_W = mrtu_pkg::FRAME_IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(mrtu_pkg::FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0] BODY_IDX = IDX_W'(mrtu_pkg::REQ_BODY_BYTES);

  mrtu_pkg::entry_t cur_r;
  logic             cur_valid_r;
  logic [IDX_W-1:0] idx_r;
  logic [15:0]      crc_r;
  logic             fire, done;
  logic [7:0]       body_byte;

  assign fire  = cur_valid_r && !out_stall;
  assign done  = !cur_r.is_frame || (idx_r == LAST_IDX);
  assign q_pop = !q_empty && (!cur_valid_r || (fire && done));

  always_comb begin
    body_byte = 8'h00;
    for (int i = 0; i < mrtu_pkg::REQ_BODY_BYTES; i++) begin
      if (idx_r == IDX_W'(i)) begin
        body_byte = cur_r.body[i];
      end
    end
  end

  always_comb begin
    out_tx_byte = 8'h00;
    if (cur_r.is_frame) begin
      if (idx_r < BODY_IDX) begin
        out_tx_byte = body_byte;
      end else if (idx_r == BODY_IDX) begin
        out_tx_byte = mrtu_pkg::crc_first(crc_r, crc_high_first);
      end else begin
        out_tx_byte = mrtu_pkg::crc_second(crc_r, crc_high_first);
      end
    end
  end

  assign out_valid     = cur_valid_r;
  assign out_tx_valid  = cur_r.is_frame;
  assign out_last      = done;
  assign out_accepted  = cur_r.accepted;
  assign out_status    = cur_r.status;
  assign out_read_data = cur_r.read_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
    end else if (fire && done) begin
      cur_valid_r <= 1'b0;
    end
  end

  // Fold each body byte into the CRC as it leaves
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
      idx_r <= '0;
      crc_r <= mrtu_pkg::CRC_INIT;
    end else if (fire && !done) begin
      idx_r <= idx_r + 1'b1;
      if (idx_r < BODY_IDX) begin
        crc_r <= mrtu_pkg::crc_add(crc_r, body_byte);
      end
    end
  end

endmodule

// ----- rtl/core/modbus_rtu_master_transaction_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_master_transaction_core
// Modbus RTU master for single-register write and read transactions.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per accepted item (start write, start read, received
//           line byte, timer tick). Accepted when in_valid is high and
//           in_stall low.
//   out_* : result items. A taken start gives 8 results, the request frame
//           bytes with the CRC last, out_last on the eighth. Every other item
//           gives one result carrying the link status and reply data.
//   APB   : seven registers at 4*i (six byte-wide, one bit wide); the user
//           writes them only while the core is idle; this is not enforced.
// Flow: a taken request is queued at the accepting edge and loaded into the
//   output register once that is free, and the result is offered from there.
// Throughput: one request per cycle while the queue has room; a start
//   holds the output side while its frame bytes stream out, and the 4-entry
//   queue between the request and output sides absorbs requests meanwhile.
// Stall: out_stall holds the current result; the queue fills and in_stall
//   rises when it is full.
// Reset: registers return to defaults, status goes to ready, queue empties.
// ----------------------------------------------------------------------------
module modbus_rtu_master_transaction_core #(
  parameter int unsigned QUEUE_DEPTH = mrtu_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_operation,
  input  logic [15:0]                       in_reg_address,
  input  logic [15:0]                       in_write_value,
  input  logic [7:0]                        in_rx_byte,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_tx_byte,
  output logic                              out_tx_valid,
  output logic                              out_last,
  output logic                              out_accepted,
  output logic [2:0]                        out_status,
  output logic [15:0]                       out_read_data,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mrtu_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [mrtu_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [mrtu_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  mrtu_pkg::cfg_t   cfg_r;
  mrtu_pkg::entry_t push_entry, pop_entry;
  logic             q_full, q_empty, q_pop, in_accept, cfg_we;
  logic [2:0]       reg_idx;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slave_address       <= mrtu_pkg::RST_SLAVE_ADDRESS;
      cfg_r.write_code          <= mrtu_pkg::RST_WRITE_CODE;
      cfg_r.read_code           <= mrtu_pkg::RST_READ_CODE;
      cfg_r.crc_error_code      <= mrtu_pkg::RST_CRC_ERROR_CODE;
      cfg_r.register_error_code <= mrtu_pkg::RST_REGISTER_ERROR_CODE;
      cfg_r.timeout_ticks       <= mrtu_pkg::RST_TIMEOUT_TICKS;
      cfg_r.crc_high_first      <= mrtu_pkg::RST_CRC_HIGH_FIRST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        mrtu_pkg::REG_SLAVE_ADDRESS:       cfg_r.slave_address <= pwdata[7:0];
        mrtu_pkg::REG_WRITE_CODE:          cfg_r.write_code <= pwdata[7:0];
        mrtu_pkg::REG_READ_CODE:           cfg_r.read_code <= pwdata[7:0];
        mrtu_pkg::REG_CRC_ERROR_CODE:      cfg_r.crc_error_code <= pwdata[7:0];
        mrtu_pkg::REG_REGISTER_ERROR_CODE: cfg_r.register_error_code <= pwdata[7:0];
        mrtu_pkg::REG_TIMEOUT_TICKS:       cfg_r.timeout_ticks <= pwdata[7:0];
        mrtu_pkg::REG_CRC_HIGH_FIRST:      cfg_r.crc_high_first <= pwdata[0];
        default: ;  // drop writes past the last register
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      mrtu_pkg::REG_SLAVE_ADDRESS:       prdata[7:0] = cfg_r.slave_address;
      mrtu_pkg::REG_WRITE_CODE:          prdata[7:0] = cfg_r.write_code;
      mrtu_pkg::REG_READ_CODE:           prdata[7:0] = cfg_r.read_code;
      mrtu_pkg::REG_CRC_ERROR_CODE:      prdata[7:0] = cfg_r.crc_error_code;
      mrtu_pkg::REG_REGISTER_ERROR_CODE: prdata[7:0] = cfg_r.register_error_code;
      mrtu_pkg::REG_TIMEOUT_TICKS:       prdata[7:0] = cfg_r.timeout_ticks;
      mrtu_pkg::REG_CRC_HIGH_FIRST:      prdata[0] = cfg_r.crc_high_first;
      default:                           prdata = '0;
    endcase
  end

  // Request side: take a request whenever the queue has room
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  mrtu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (in_accept),
    .operation   (in_operation),
    .reg_address (in_reg_address),
    .write_value (in_write_value),
    .rx_byte     (in_rx_byte),
    .entry       (push_entry)
  );

  mrtu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_entry),
    .empty     (q_empty)
  );

  // Result side: stream frames and status reports
  mrtu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .crc_high_first (cfg_r.crc_high_first),
    .q_empty        (q_empty),
    .q_data         (pop_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tx_byte    (out_tx_byte),
    .out_tx_valid   (out_tx_valid),
    .out_last       (out_last),
    .out_accepted   (out_accepted),
    .out_status     (out_status),
    .out_read_data  (out_read_data)
  );

endmodule

// ----- rtl/core/mrtu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrtu_checker
// Port-level checks of the Modbus RTU master core, bound to the top level.
// ----------------------------------------------------------------------------
module mrtu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_tx_byte,
  input logic        out_tx_valid,
  input logic        out_last,
  input logic        out_accepted,
  input logic [2:0]  out_status,
  input logic [15:0] out_read_data
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte) && $stable(out_last)
                               && $stable(out_status))
    else $error("stalled result changed");

  // Frame bytes only belong to a taken start, with the link receiving
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid |-> out_accepted &&
      out_status == mrtu_pkg::ST_RECEIVING && out_read_data == 16'h0000)
    else $error("frame byte outside a taken start");

  // A single-result item carries no byte and ends its run
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_valid |-> out_tx_byte == 8'h00 && out_last && !out_accepted)
    else $error("malformed status result");

  // Reply data shows only once a full reply has settled
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != mrtu_pkg::ST_OK && out_status != mrtu_pkg::ST_FRAME_ERR
      |-> out_read_data == 16'h0000)
    else $error("read data without a settled reply");

endmodule

bind modbus_rtu_master_transaction_core mrtu_checker u_mrtu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_tx_byte   (out_tx_byte),
  .out_tx_valid  (out_tx_valid),
  .out_last      (out_last),
  .out_accepted  (out_accepted),
  .out_status    (out_status),
  .out_read_data (out_read_data)
);
